[rtl/core/lsft_pkg.sv]
// lsft_pkg: shared constants and controller/datapath handshake types
// for the learning switch forwarding table; no dependencies
package lsft_pkg;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 2;
    localparam int MASK_W = 4;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_NUM_PORTS   = 4;
    localparam int DEF_ADDR_WIDTH  = 48;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } lsft_cmd_t;

    typedef struct packed {
        logic scan_done;
    } lsft_status_t;

endpackage

[rtl/core/lsft_if.sv]
// lsft_req_if, lsft_rsp_if: valid/ready channels for frame header requests
// and forwarding results; depends on lsft_pkg
interface lsft_req_if
    import lsft_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dest_mac;
    logic [PORT_W-1:0] in_port;
    logic              is_arp_request;

    modport source (output valid, src_mac, dest_mac, in_port, is_arp_request, input ready);
    modport sink (input valid, src_mac, dest_mac, in_port, is_arp_request, output ready);
    modport monitor (input valid, ready, src_mac, dest_mac, in_port, is_arp_request);
endinterface

interface lsft_rsp_if
    import lsft_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic              learned_new;
    logic              table_full;

    modport source (output valid, egress_mask, flooded, learned_new, table_full, input ready);
    modport sink (input valid, egress_mask, flooded, learned_new, table_full, output ready);
    modport monitor (input valid, ready, egress_mask, flooded, learned_new, table_full);
endinterface

[rtl/core/learning_switch_forward_table.sv]
// learning_switch_forward_table: learning bridge address table with flood/forward decision
// requests: one at a time; each scans the ram one entry per cycle, then its result is registered;
//   a result held by the receiver adds its stall
// reset: asynchronous active low, empties the table (fill count to zero), no clearing pass
// depends on lsft_pkg, lsft_if, lsft_ctrl, lsft_dp, lsft_ram
module learning_switch_forward_table
    import lsft_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NUM_PORTS   = DEF_NUM_PORTS,
    parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH
) (
    input logic        clk,
    input logic        rst_n,
    lsft_req_if.sink   req,
    lsft_rsp_if.source rsp
);

    lsft_cmd_t    cmd;
    lsft_status_t status;

    lsft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lsft_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_PORTS   (NUM_PORTS),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .src_mac        (req.src_mac),
        .dest_mac       (req.dest_mac),
        .in_port        (req.in_port),
        .is_arp_request (req.is_arp_request),
        .egress_mask    (rsp.egress_mask),
        .flooded        (rsp.flooded),
        .learned_new    (rsp.learned_new),
        .table_full     (rsp.table_full)
    );

endmodule

[rtl/core/lsft_ram.sv]
// lsft_ram: generic single write port, single read port ram with registered read
// no dependencies
module lsft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lsft_ctrl.sv]
// lsft_ctrl: sequencing state machine and channel handshakes
// depends on lsft_pkg
module lsft_ctrl
    import lsft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  lsft_status_t status,
    output lsft_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the result slot to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/lsft_dp.sv]
// lsft_dp: request registers, table scan and compare, learning write, result registers
// depends on lsft_pkg and lsft_ram
module lsft_dp
    import lsft_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NUM_PORTS   = DEF_NUM_PORTS,
    parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lsft_cmd_t         cmd,
    output lsft_status_t      status,
    input  logic [MAC_W-1:0]  src_mac,
    input  logic [MAC_W-1:0]  dest_mac,
    input  logic [PORT_W-1:0] in_port,
    input  logic              is_arp_request,
    output logic [MASK_W-1:0] egress_mask,
    output logic              flooded,
    output logic              learned_new,
    output logic              table_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = ADDR_WIDTH + PORT_W;

    logic [ADDR_WIDTH-1:0] src_reg, dst_reg;
    logic [PORT_W-1:0]     port_reg;
    logic                  arp_reg;
    logic [CNT_W-1:0]      idx_reg, count_reg;
    logic                  pend_reg;
    logic                  src_hit_reg, dst_hit_reg;
    logic [PORT_W-1:0]     dst_port_reg;
    logic [MASK_W-1:0]     egress_mask_reg;
    logic                  flooded_reg, learned_reg, full_reg;

    logic                  rd_en, wr_en, learn_ok, dst_hit;
    logic [ENT_W-1:0]      rdata;
    logic [ADDR_WIDTH-1:0] ent_key;
    logic [PORT_W-1:0]     ent_port, hit_port;
    logic [MASK_W-1:0]     ports_mask, mask_next;

    assign rd_en    = cmd.scan && (idx_reg != count_reg);
    assign ent_key  = rdata[ENT_W-1:PORT_W];
    assign ent_port = rdata[PORT_W-1:0];
    assign learn_ok = !src_hit_reg && (count_reg != CNT_W'(TABLE_DEPTH));
    assign wr_en    = cmd.finish && learn_ok;
    assign dst_hit  = dst_hit_reg || (learn_ok && (dst_reg == src_reg));
    assign hit_port = dst_hit_reg ? dst_port_reg : port_reg;

    assign status.scan_done = (idx_reg == count_reg) && !pend_reg;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            ports_mask[i] = (i < NUM_PORTS);
        end
        if (dst_hit && !arp_reg)
        begin
            mask_next = (MASK_W'(1) << hit_port) & ports_mask;
        end
        else
        begin
            mask_next = ports_mask & ~(MASK_W'(1) << port_reg);
        end
    end

    lsft_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({src_reg, port_reg}),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= rd_en;
                if (rd_en)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            src_reg     <= src_mac[ADDR_WIDTH-1:0];
            dst_reg     <= dest_mac[ADDR_WIDTH-1:0];
            port_reg    <= in_port;
            arp_reg     <= is_arp_request;
            src_hit_reg <= 1'b0;
            dst_hit_reg <= 1'b0;
        end
        else if (pend_reg)
        begin
            if (ent_key == src_reg)
            begin
                src_hit_reg <= 1'b1;
            end
            if (ent_key == dst_reg)
            begin
                dst_hit_reg  <= 1'b1;
                dst_port_reg <= ent_port;
            end
        end
        if (cmd.finish)
        begin
            egress_mask_reg <= mask_next;
            flooded_reg     <= !(dst_hit && !arp_reg);
            learned_reg     <= learn_ok;
            full_reg        <= !src_hit_reg && !learn_ok;
        end
    end

    assign egress_mask = egress_mask_reg;
    assign flooded     = flooded_reg;
    assign learned_new = learned_reg;
    assign table_full  = full_reg;

endmodule

[rtl/core/lsft_checker.sv]
// lsft_checker: port-level assertions for learning_switch_forward_table, bound to the top
// depends on lsft_pkg and lsft_if
module lsft_checker
    import lsft_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    lsft_req_if.sink   req,
    lsft_rsp_if.source rsp
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while previous one still in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid)
        else $error("result dropped before taken");

    a_learn_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.learned_new && rsp.table_full))
        else $error("learned and full reported together");

    a_fwd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.flooded |-> $onehot0(rsp.egress_mask))
        else $error("forwarded result with more than one egress port");

endmodule

bind learning_switch_forward_table lsft_checker u_lsft_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench for learning_switch_forward_table: a directed table, then random frame headers,
// with each result checked against its typed row or a local model of the address table
// depends on lsft_pkg and the lsft_req_if / lsft_rsp_if interfaces
module testbench;
    import lsft_pkg::*;

    localparam int DEPTH       = DEF_TABLE_DEPTH;
    localparam int PORTS       = DEF_NUM_PORTS;
    localparam int RANDOM_N    = 950;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 80;
    localparam int HOLD_CYCLES = 300;

    localparam logic [MAC_W-1:0] MAC_ZERO = '0;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;
    localparam logic [MAC_W-1:0] MAC_AAAA = 48'hAAAA_AAAA_AAAA;
    localparam logic [MAC_W-1:0] MAC_5555 = 48'h5555_5555_5555;
    localparam logic [MAC_W-1:0] MAC_UCST = 48'h0200_0000_0001;
    localparam logic [MAC_W-1:0] MAC_MCST = 48'h0180_C200_0000;
    localparam logic [MAC_W-1:0] MAC_LOW1 = 48'h0000_0000_0001;
    localparam logic [MAC_W-1:0] MAC_TOP1 = 48'h8000_0000_0000;
    localparam logic [MAC_W-1:0] MAC_MIX  = 48'h1234_5678_9ABC;

    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dest_mac;
        logic [PORT_W-1:0] in_port;
        logic              is_arp_request;
    } frame_hdr_t;

    typedef struct packed {
        logic [MASK_W-1:0] egress_mask;
        logic              flooded;
        logic              learned_new;
        logic              table_full;
    } fwd_result_t;

    typedef struct packed {
        frame_hdr_t  hdr;
        logic        typed;
        fwd_result_t res;
    } dir_row_t;

    localparam int DIR_N = 15;

    // typed rows: egress_mask, flooded, learned_new, table_full
    dir_row_t directed_rows [DIR_N] = '{
        '{'{MAC_ZERO, MAC_ONES, 2'd0, 1'b0}, 1'b1, '{4'hE, 1'b1, 1'b1, 1'b0}},
        '{'{MAC_ONES, MAC_ZERO, 2'd3, 1'b0}, 1'b1, '{4'h1, 1'b0, 1'b1, 1'b0}},
        '{'{MAC_ZERO, MAC_ZERO, 2'd2, 1'b0}, 1'b1, '{4'h1, 1'b0, 1'b0, 1'b0}},
        '{'{MAC_AAAA, MAC_AAAA, 2'd1, 1'b0}, 1'b1, '{4'h2, 1'b0, 1'b1, 1'b0}},
        '{'{MAC_ONES, MAC_ZERO, 2'd3, 1'b1}, 1'b1, '{4'h7, 1'b1, 1'b0, 1'b0}},
        '{'{MAC_5555, MAC_ONES, 2'd2, 1'b0}, 1'b1, '{4'h8, 1'b0, 1'b1, 1'b0}},
        '{'{MAC_ONES, MAC_ONES, 2'd3, 1'b0}, 1'b1, '{4'h8, 1'b0, 1'b0, 1'b0}},
        '{'{MAC_ZERO, MAC_UCST, 2'd1, 1'b0}, 1'b1, '{4'hD, 1'b1, 1'b0, 1'b0}},
        '{'{MAC_UCST, MAC_UCST, 2'd0, 1'b1}, 1'b1, '{4'hE, 1'b1, 1'b1, 1'b0}},
        '{'{MAC_MCST, MAC_5555, 2'd2, 1'b1}, 1'b1, '{4'hB, 1'b1, 1'b1, 1'b0}},
        '{'{MAC_5555, MAC_MCST, 2'd1, 1'b0}, 1'b1, '{4'h4, 1'b0, 1'b0, 1'b0}},
        '{'{MAC_LOW1, MAC_TOP1, 2'd3, 1'b0}, 1'b0, '{4'h0, 1'b0, 1'b0, 1'b0}},
        '{'{MAC_TOP1, MAC_LOW1, 2'd1, 1'b0}, 1'b0, '{4'h0, 1'b0, 1'b0, 1'b0}},
        '{'{MAC_MIX,  MAC_AAAA, 2'd2, 1'b1}, 1'b0, '{4'h0, 1'b0, 1'b0, 1'b0}},
        '{'{MAC_AAAA, MAC_MIX,  2'd0, 1'b0}, 1'b0, '{4'h0, 1'b0, 1'b0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    lsft_req_if req_ch ();
    lsft_rsp_if rsp_ch ();

    learning_switch_forward_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [MAC_W-1:0]  station_key  [DEPTH];
    logic [PORT_W-1:0] station_port [DEPTH];
    bit                station_used [DEPTH];
    int                station_count;

    fwd_result_t pending_fwd [$];
    int          mismatches;
    int          results_seen;
    int          cycles;
    bit          no_idle;
    bit          hold_rsp_req;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // learn source, then look up destination
    function automatic fwd_result_t forward_decision(input frame_hdr_t h);
        fwd_result_t r;
        int          i;
        int          src_slot;
        int          free_slot;
        int          dst_slot;
        logic [MASK_W-1:0] ports_mask;

        ports_mask = MASK_W'((1 << PORTS) - 1);
        r = '0;
        src_slot = -1;
        free_slot = -1;
        for (i = 0; i < DEPTH; i++)
        begin
            if (station_used[i] && station_key[i] == h.src_mac && src_slot < 0)
                src_slot = i;
            if (!station_used[i] && free_slot < 0)
                free_slot = i;
        end
        if (src_slot < 0)
        begin
            if (free_slot >= 0 && station_count < DEPTH)
            begin
                station_key[free_slot]  = h.src_mac;
                station_port[free_slot] = h.in_port;
                station_used[free_slot] = 1'b1;
                station_count++;
                r.learned_new = 1'b1;
            end
            else
                r.table_full = 1'b1;
        end
        dst_slot = -1;
        for (i = 0; i < DEPTH; i++)
            if (station_used[i] && station_key[i] == h.dest_mac && dst_slot < 0)
                dst_slot = i;
        if (dst_slot >= 0 && !h.is_arp_request)
            r.egress_mask = (MASK_W'(1) << station_port[dst_slot]) & ports_mask;
        else
        begin
            r.egress_mask = ports_mask & ~(MASK_W'(1) << h.in_port);
            r.flooded = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] fresh_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    function automatic logic [MAC_W-1:0] known_mac();
        if (station_count == 0)
            return fresh_mac();
        return station_key[$urandom_range(station_count - 1)];
    endfunction

    function automatic frame_hdr_t random_frame();
        frame_hdr_t h;
        int         pick;

        pick = $urandom_range(99);
        if (pick < 4)
            h.src_mac = pick[0] ? MAC_ONES : MAC_ZERO;
        else if (pick < 19)
            h.src_mac = fresh_mac();
        else
            h.src_mac = known_mac();
        pick = $urandom_range(99);
        if (pick < 55)
            h.dest_mac = known_mac();
        else if (pick < 65)
            h.dest_mac = h.src_mac;
        else if (pick < 70)
            h.dest_mac = pick[0] ? MAC_ONES : MAC_ZERO;
        else
            h.dest_mac = fresh_mac();
        h.in_port = PORT_W'($urandom_range((1 << PORT_W) - 1));
        h.is_arp_request = ($urandom_range(99) < 15);
        return h;
    endfunction

    task automatic offer_frame(input frame_hdr_t h, input bit typed, input fwd_result_t typed_res);
        fwd_result_t predicted;

        while (!no_idle && $urandom_range(99) < 15)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.src_mac        <= h.src_mac;
        req_ch.dest_mac       <= h.dest_mac;
        req_ch.in_port        <= h.in_port;
        req_ch.is_arp_request <= h.is_arp_request;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = forward_decision(h);
        pending_fwd.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    initial
    begin
        int n;

        req_ch.valid          = 1'b0;
        req_ch.src_mac        = '0;
        req_ch.dest_mac       = '0;
        req_ch.in_port        = '0;
        req_ch.is_arp_request = 1'b0;
        rst_n         = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        station_count = 0;
        no_idle       = 1'b0;
        hold_rsp_req  = 1'b0;
        for (n = 0; n < DEPTH; n++)
        begin
            station_key[n]  = '0;
            station_port[n] = '0;
            station_used[n] = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < DIR_N; n++)
            offer_frame(directed_rows[n].hdr, directed_rows[n].typed, directed_rows[n].res);

        for (n = 0; n < RANDOM_N; n++)
        begin
            no_idle = (n >= 300 && n < 420);
            if (n == 550)
                hold_rsp_req = 1'b1;
            if (n == 700)
            begin
                req_ch.valid <= 1'b0;
                while (pending_fwd.size() != 0)
                    @(negedge clk);
            end
            offer_frame(random_frame(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_fwd.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        bit held;

        held = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp_req && !held)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        fwd_result_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_fwd.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          results_seen));
            else
            begin
                want = pending_fwd.pop_front();
                if (rsp_ch.egress_mask !== want.egress_mask)
                    report_mismatch($sformatf("result %0d egress_mask got %0h expected %0h",
                                              results_seen, rsp_ch.egress_mask,
                                              want.egress_mask));
                if (rsp_ch.flooded !== want.flooded)
                    report_mismatch($sformatf("result %0d flooded got %0b expected %0b",
                                              results_seen, rsp_ch.flooded, want.flooded));
                if (rsp_ch.learned_new !== want.learned_new)
                    report_mismatch($sformatf("result %0d learned_new got %0b expected %0b",
                                              results_seen, rsp_ch.learned_new,
                                              want.learned_new));
                if (rsp_ch.table_full !== want.table_full)
                    report_mismatch($sformatf("result %0d table_full got %0b expected %0b",
                                              results_seen, rsp_ch.table_full,
                                              want.table_full));
            end
            results_seen++;
        end
    end

endmodule

[filelist.f]
rtl/core/lsft_pkg.sv
rtl/core/lsft_if.sv
rtl/core/lsft_ram.sv
rtl/core/lsft_ctrl.sv
rtl/core/lsft_dp.sv
rtl/core/learning_switch_forward_table.sv
rtl/core/lsft_checker.sv
tb/testbench.sv
